// File: rtl/core/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types, sizes and helpers shared by the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 10;
	localparam int OCC_W      = 11;
	localparam int SUM_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		CMD_ADD_BACK   = 3'd0,
		CMD_ADD_FRONT  = 3'd1,
		CMD_DROP_FRONT = 3'd2,
		CMD_DROP_BACK  = 3'd3,
		CMD_SET_TAIL   = 3'd4,
		CMD_SET_HEAD   = 3'd5,
		CMD_READ_IDX   = 3'd6,
		CMD_CLEAR      = 3'd7
	} dq_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} dq_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_READ,
		FSM_LOAD
	} dq_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
		logic load;
	} dq_ctl_t;

	// ring index base + off, for off below DEPTH
	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
	                                               input logic [SUM_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + off;
		if (sum >= SUM_W'(DEPTH))
			sum = sum - SUM_W'(DEPTH);
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// File: rtl/core/dq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface dq_req_if;
	import dq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [2:0]               command;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [OCC_W-1:0]         occupancy;
	logic                     is_empty;

	modport source (output valid, status, read_value, front_value, back_value,
	                occupancy, is_empty, input ready);
	modport sink   (input valid, status, read_value, front_value, back_value,
	                occupancy, is_empty, output ready);
endinterface

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring buffer.
//
// req carries one command per transfer (push/pop at either end, overwrite
// head or tail, indexed read, clear) with its data word and index.
// rsp returns one result per command: status, the word read, and the front,
// back and count of the queue after the command.
// A command is taken only from the idle state; it then steps through the
// execute, read-back and load states around the single store, and the next
// command is not taken until the sequence returns to idle.
// The result sits in an output register; a new command is taken while it
// waits, and the next result is held back until rsp accepts the previous one.
// Reset empties the queue and clears the head pointer; the store itself is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input logic      clk,
	input logic      arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	dq_ctl_t ctl;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	dq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (req.command),
		.value       (req.value),
		.position    (req.position),
		.status      (rsp.status),
		.read_value  (rsp.read_value),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value),
		.occupancy   (rsp.occupancy),
		.is_empty    (rsp.is_empty)
	);
endmodule

// File: rtl/core/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// File: rtl/core/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture, execute, read back, load result register.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dq_pkg::dq_ctl_t ctl
);
	import dq_pkg::*;

	dq_state_t state_q, state_d;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.capture = 1'b1;
					state_d     = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = FSM_READ;
			end
			FSM_READ: begin
				ctl.read = 1'b1;
				state_d  = FSM_LOAD;
			end
			FSM_LOAD: begin
				if (!out_valid_q || rsp_ready) begin
					ctl.load = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.load)
			out_valid_q <= 1'b1;
		else if (rsp_ready)
			out_valid_q <= 1'b0;
	end

	assign rsp_valid = out_valid_q;
endmodule

// File: rtl/core/dq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, element store and result register.
// ----------------------------------------------------------------------------
module dq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::dq_ctl_t                  ctl,
	input  logic [2:0]                       command,
	input  logic signed [dq_pkg::DATA_W-1:0] value,
	input  logic [dq_pkg::POS_W-1:0]         position,
	output logic [1:0]                       status,
	output logic signed [dq_pkg::DATA_W-1:0] read_value,
	output logic signed [dq_pkg::DATA_W-1:0] front_value,
	output logic signed [dq_pkg::DATA_W-1:0] back_value,
	output logic [dq_pkg::OCC_W-1:0]         occupancy,
	output logic                             is_empty
);
	import dq_pkg::*;

	dq_cmd_t           cmd_q;
	logic [DATA_W-1:0] value_q;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	dq_status_t        stat_q;
	logic [DATA_W-1:0] read_q;

	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	dq_status_t        stat_d;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;
	logic              empty;
	logic              full;
	logic [SUM_W-1:0]  last_off;

	assign empty    = (count_q == '0);
	assign full     = (count_q >= CNT_W'(DEPTH));
	assign last_off = SUM_W'(count_q) - SUM_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= dq_cmd_t'(command);
			value_q <= value;
			pos_q   <= position;
		end
	end

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		stat_d  = ST_DONE;
		we      = 1'b0;
		waddr   = head_q;
		case (cmd_q)
			CMD_ADD_BACK: begin
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					we      = 1'b1;
					waddr   = ring_add(head_q, SUM_W'(count_q));
					count_d = count_q + 1'b1;
				end
			end
			CMD_ADD_FRONT: begin
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					head_d  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
					we      = 1'b1;
					waddr   = head_d;
					count_d = count_q + 1'b1;
				end
			end
			CMD_DROP_FRONT: begin
				if (empty) begin
					stat_d = ST_EMPTY;
				end else begin
					head_d  = ring_add(head_q, SUM_W'(1));
					count_d = count_q - 1'b1;
				end
			end
			CMD_DROP_BACK: begin
				if (empty)
					stat_d = ST_EMPTY;
				else
					count_d = count_q - 1'b1;
			end
			CMD_SET_TAIL: begin
				if (empty) begin
					stat_d = ST_EMPTY;
				end else begin
					we    = 1'b1;
					waddr = ring_add(head_q, last_off);
				end
			end
			CMD_SET_HEAD: begin
				if (empty)
					stat_d = ST_EMPTY;
				else
					we = 1'b1;
			end
			CMD_READ_IDX: begin
				if (SUM_W'(pos_q) >= SUM_W'(count_q))
					stat_d = ST_RANGE;
			end
			CMD_CLEAR: begin
				head_d  = '0;
				count_d = '0;
			end
			default: stat_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec)
			stat_q <= stat_d;
	end

	// exec: index read against the old head; read: new front and back
	assign raddr_a = ctl.exec ? ring_add(head_q, SUM_W'(pos_q)) : head_q;
	assign raddr_b = ring_add(head_q, last_off);

	dq_ram #(
		.DATA_W (DATA_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (we & ctl.exec),
		.waddr   (waddr),
		.wdata   (value_q),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk) begin
		if (ctl.read)
			read_q <= (cmd_q == CMD_READ_IDX && stat_q == ST_DONE) ? rdata_a : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status      <= stat_q;
			read_value  <= read_q;
			front_value <= empty ? '0 : rdata_a;
			back_value  <= empty ? '0 : rdata_b;
			occupancy   <= OCC_W'(count_q);
			is_empty    <= empty;
		end
	end
endmodule
